@@ rtl/pic_pkg.sv @@
// ----------------------------------------------------------------------------
// Pedigree inbreeding coefficients: shared package
// Item types, fixed-point constants, datapath operations and the command and
// status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package pic_pkg;

  localparam int MAX_ANIMALS_DEF = 4096;
  localparam int FRAC_BITS       = 30;
  localparam int NUM_W           = 13;
  localparam int F_W             = 31;
  localparam int CONT_W          = 32;

  localparam logic [63:0]    FIX_ONE = 64'd1 << FRAC_BITS;
  localparam logic [F_W-1:0] F_ONE   = F_W'(64'd1 << FRAC_BITS);
  localparam logic [F_W-1:0] F_HALF  = F_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic [F_W-1:0] F_QUART = F_W'(64'd1 << (FRAC_BITS - 2));

  typedef struct packed {
    logic             restart;
    logic [NUM_W-1:0] sire;
    logic [NUM_W-1:0] dam;
  } in_item_t;

  typedef struct packed {
    logic [NUM_W-1:0] animal_number;
    logic [F_W-1:0]   inbreeding;
    logic             error;
  } out_item_t;

  // Contribution entry: queued flag and accumulated contribution.
  typedef struct packed {
    logic              flag;
    logic [CONT_W-1:0] c;
  } cont_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_ACCEPT,
    OP_CHECK,
    OP_PARENTS,
    OP_INC_RD,
    OP_INC_WR,
    OP_STORE,
    OP_WINIT,
    OP_LVL_RD,
    OP_LVL_POP,
    OP_POP_RD,
    OP_POP_LATCH,
    OP_PAR_RD,
    OP_PAR_UPD,
    OP_PAR_PUSH,
    OP_ACC,
    OP_RESULT,
    OP_FIN,
    OP_ERR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic err;
    logic no_walk;
    logic lap_done;
    logic lvl_empty;
    logic t_zero;
    logic par_zero;
    logic par_seen;
    logic par_last;
    logic lvl_done;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/pic_ctrl.sv @@
// ----------------------------------------------------------------------------
// Pedigree inbreeding coefficients: controller
// Sequences one record through check, level count update, table store and the
// deepest-first ancestor walk, one datapath operation per cycle unless held.
// ----------------------------------------------------------------------------
module pic_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  pic_pkg::stat_t  stat,
  output pic_pkg::cmd_t   cmd
);

  typedef enum logic [18:0] {
    S_CLR       = 19'h00001,
    S_IDLE      = 19'h00002,
    S_CHK       = 19'h00004,
    S_PAR       = 19'h00008,
    S_INC_RD    = 19'h00010,
    S_INC_WR    = 19'h00020,
    S_STORE     = 19'h00040,
    S_WINIT     = 19'h00080,
    S_LVL_RD    = 19'h00100,
    S_LVL_POP   = 19'h00200,
    S_POP_RD    = 19'h00400,
    S_POP_LATCH = 19'h00800,
    S_PAR_RD    = 19'h01000,
    S_PAR_UPD   = 19'h02000,
    S_PAR_PUSH  = 19'h04000,
    S_ACC       = 19'h08000,
    S_RES       = 19'h10000,
    S_FIN       = 19'h20000,
    S_ERR       = 19'h40000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = pic_pkg::OP_NONE;
    case (state_r)
      S_CLR: begin
        cmd.op = pic_pkg::OP_CLR;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = pic_pkg::OP_ACCEPT;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cmd.op    = pic_pkg::OP_CHECK;
        state_nxt = stat.err ? S_ERR : S_PAR;
      end
      S_PAR: begin
        cmd.op    = pic_pkg::OP_PARENTS;
        state_nxt = S_INC_RD;
      end
      S_INC_RD: begin
        cmd.op    = pic_pkg::OP_INC_RD;
        state_nxt = S_INC_WR;
      end
      S_INC_WR: begin
        cmd.op    = pic_pkg::OP_INC_WR;
        state_nxt = stat.lap_done ? S_STORE : S_INC_RD;
      end
      S_STORE: begin
        cmd.op    = pic_pkg::OP_STORE;
        state_nxt = stat.no_walk ? S_FIN : S_WINIT;
      end
      S_WINIT: begin
        cmd.op    = pic_pkg::OP_WINIT;
        state_nxt = S_LVL_RD;
      end
      S_LVL_RD: begin
        cmd.op    = pic_pkg::OP_LVL_RD;
        state_nxt = S_LVL_POP;
      end
      S_LVL_POP: begin
        cmd.op = pic_pkg::OP_LVL_POP;
        if (!stat.lvl_empty) begin
          state_nxt = S_POP_RD;
        end else begin
          state_nxt = stat.t_zero ? S_RES : S_LVL_RD;
        end
      end
      S_POP_RD: begin
        cmd.op    = pic_pkg::OP_POP_RD;
        state_nxt = S_POP_LATCH;
      end
      S_POP_LATCH: begin
        cmd.op    = pic_pkg::OP_POP_LATCH;
        state_nxt = S_PAR_RD;
      end
      S_PAR_RD: begin
        cmd.op = pic_pkg::OP_PAR_RD;
        if (!stat.par_zero) begin
          state_nxt = S_PAR_UPD;
        end else begin
          state_nxt = stat.par_last ? S_ACC : S_PAR_RD;
        end
      end
      S_PAR_UPD: begin
        cmd.op = pic_pkg::OP_PAR_UPD;
        if (!stat.par_seen) begin
          state_nxt = S_PAR_PUSH;
        end else begin
          state_nxt = stat.par_last ? S_ACC : S_PAR_RD;
        end
      end
      S_PAR_PUSH: begin
        cmd.op    = pic_pkg::OP_PAR_PUSH;
        state_nxt = stat.par_last ? S_ACC : S_PAR_RD;
      end
      S_ACC: begin
        cmd.op = pic_pkg::OP_ACC;
        if (stat.lvl_done && stat.t_zero) begin
          state_nxt = S_RES;
        end else begin
          state_nxt = S_LVL_RD;
        end
      end
      S_RES: begin
        cmd.op    = pic_pkg::OP_RESULT;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.op    = pic_pkg::OP_FIN;
          state_nxt = S_IDLE;
        end
      end
      S_ERR: begin
        if (stat.out_free) begin
          cmd.op    = pic_pkg::OP_ERR;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

endmodule

@@ rtl/pic_dp.sv @@
// ----------------------------------------------------------------------------
// Pedigree inbreeding coefficients: datapath
// Animal tables, per-level count and fill memories, the ancestor stack, the
// contribution memory, the squared-contribution times variance multiplier
// chain and the result register.
// ----------------------------------------------------------------------------
module pic_dp #(
  parameter int MAX_ANIMALS = pic_pkg::MAX_ANIMALS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pic_pkg::in_item_t   in_data,
  input  pic_pkg::cmd_t       cmd,
  input  logic                out_stall,
  output pic_pkg::stat_t      stat,
  output logic                out_valid,
  output pic_pkg::out_item_t  out_data
);

  localparam int TBL = MAX_ANIMALS + 1;
  localparam int NW  = $clog2(TBL);
  localparam int LW  = $clog2(MAX_ANIMALS);
  localparam int FW  = pic_pkg::F_W;
  localparam int CW  = pic_pkg::CONT_W;
  localparam int SQW = 2 * CW - pic_pkg::FRAC_BITS;
  localparam int PW  = 66 - pic_pkg::FRAC_BITS;
  localparam int NUM_W_L = pic_pkg::NUM_W;

  localparam logic [LW-1:0] LAP_MAX  = LW'(MAX_ANIMALS - 1);
  localparam logic [NW-1:0] CNT_MAX  = NW'(MAX_ANIMALS);
  localparam logic [NW-1:0] TBL_LAST = NW'(TBL - 1);
  localparam logic [LW:0]   HW_MAX   = (LW + 1)'(MAX_ANIMALS);

  // Memories.
  logic [NW-1:0]  sire_mem  [TBL];
  logic [NW-1:0]  dam_mem   [TBL];
  logic [FW-1:0]  f_mem     [TBL];
  logic [FW-1:0]  var_mem   [TBL];
  logic [LW-1:0]  depth_mem [TBL];
  pic_pkg::cont_t cont_mem  [TBL];
  logic [NW-1:0]  stack_mem [TBL];
  logic [NW-1:0]  base_mem  [MAX_ANIMALS];
  logic [NW-1:0]  fill_mem  [MAX_ANIMALS];

  // Registered read data.
  logic [NW-1:0]  sire_q, dam_q, stack_q, base_q, fill_q;
  logic [FW-1:0]  f_a_q, f_b_q, var_q;
  logic [LW-1:0]  dep_a_q, dep_b_q;
  pic_pkg::cont_t cont_q;

  // Record and store state.
  logic [NUM_W_L-1:0] s_r, d_r;
  logic [NW-1:0]  count_r;
  logic [LW:0]    hiwater_r;
  logic           prev_valid_r;
  logic [NW-1:0]  prev_s_r, prev_d_r;
  logic [FW-1:0]  prev_f_r;
  logic [LW-1:0]  lap_r, k_r, t_r, p_lv_r;
  logic [FW-1:0]  var_r, f_r;
  logic [NW-1:0]  lapbase_r, pos_r, base_r, j_r, ps_r, pd_r, clr_r;
  logic [CW-1:0]  c_r;
  logic           sel_r;
  logic [63:0]    acc_r;

  // Multiplier chain.
  logic [SQW-1:0] sq_r;
  logic [FW-1:0]  v_r;
  logic [62:0]    plo_r;
  logic [32:0]    phi_r;
  logic [PW-1:0]  prod_r;

  pic_pkg::out_item_t out_r;
  logic               out_valid_r;

  // Address and control decode.
  logic [NW-1:0] s_idx, d_idx, i_idx, p_idx;
  logic          s_known, d_known, repeat_hit, out_free, load_out;

  assign s_idx      = NW'(s_r);
  assign d_idx      = NW'(d_r);
  assign i_idx      = count_r + NW'(1);
  assign p_idx      = sel_r ? pd_r : ps_r;
  assign s_known    = (s_r != '0);
  assign d_known    = (d_r != '0);
  assign repeat_hit = prev_valid_r && (prev_s_r == s_idx) && (prev_d_r == d_idx);
  assign out_free   = !out_valid_r || !out_stall;
  assign load_out   = (cmd.op == pic_pkg::OP_FIN) || (cmd.op == pic_pkg::OP_ERR);

  // Parent summary for the new record.
  logic [LW:0]   ls, ld, lap_full;
  logic [LW-1:0] lap_calc;
  logic [FW:0]   var_base, known;
  logic [FW-1:0] var_calc;

  always_comb begin
    ls       = s_known ? ({1'b0, dep_a_q} + (LW + 1)'(1)) : '0;
    ld       = d_known ? ({1'b0, dep_b_q} + (LW + 1)'(1)) : '0;
    lap_full = (ls > ld) ? ls : ld;
    lap_calc = (lap_full > {1'b0, LAP_MAX}) ? LAP_MAX : lap_full[LW-1:0];
    var_base = {1'b0, pic_pkg::F_HALF}
             + (s_known ? (FW + 1)'(0) : {1'b0, pic_pkg::F_QUART})
             + (d_known ? (FW + 1)'(0) : {1'b0, pic_pkg::F_QUART});
    known    = ((s_known ? {1'b0, f_a_q} : (FW + 1)'(0))
             +  (d_known ? {1'b0, f_b_q} : (FW + 1)'(0))) >> 2;
    var_calc = (var_base > known) ? FW'(var_base - known) : '0;
  end

  // Level count sweep value. Levels at or above the high-water mark read as 0.
  logic [NW-1:0] inc_old, inc_val;
  logic [LW:0]   lap_plus;

  assign inc_old  = ({1'b0, k_r} < hiwater_r) ? base_q : '0;
  assign inc_val  = inc_old + NW'(k_r != lap_r);
  assign lap_plus = {1'b0, lap_r} + (LW + 1)'(1);

  // Final coefficient.
  logic [63:0]   acc_sub;
  logic [FW-1:0] f_calc;

  assign acc_sub = acc_r - pic_pkg::FIX_ONE;
  assign f_calc  = (acc_r > pic_pkg::FIX_ONE)
                 ? ((acc_sub > pic_pkg::FIX_ONE) ? pic_pkg::F_ONE : acc_sub[FW-1:0])
                 : '0;

  // Memory port muxing.
  logic [NW-1:0]  cont_ra, cont_wa, stack_wa, stack_wd;
  logic [LW-1:0]  base_ra, fill_ra, lvl_wa;
  logic           cont_we, stack_we, lvl_we, fill_only_we;
  pic_pkg::cont_t cont_wd;
  logic [NW-1:0]  lvl_wd;

  always_comb begin
    cont_ra      = stack_q;
    cont_we      = 1'b0;
    cont_wa      = clr_r;
    cont_wd      = '0;
    base_ra      = t_r;
    fill_ra      = t_r;
    lvl_we       = 1'b0;
    fill_only_we = 1'b0;
    lvl_wa       = k_r;
    lvl_wd       = inc_val;
    stack_we     = 1'b0;
    stack_wa     = fill_q;
    stack_wd     = p_idx;
    case (cmd.op)
      pic_pkg::OP_CLR: begin
        cont_we = 1'b1;
      end
      pic_pkg::OP_INC_RD: begin
        base_ra = k_r;
      end
      pic_pkg::OP_INC_WR: begin
        lvl_we = 1'b1;
      end
      pic_pkg::OP_WINIT: begin
        cont_we      = 1'b1;
        cont_wa      = i_idx;
        cont_wd      = {1'b1, CW'(pic_pkg::FIX_ONE)};
        stack_we     = 1'b1;
        stack_wa     = lapbase_r;
        stack_wd     = i_idx;
        fill_only_we = 1'b1;
        lvl_wa       = lap_r;
        lvl_wd       = lapbase_r + NW'(1);
      end
      pic_pkg::OP_LVL_POP: begin
        if (fill_q > base_q) begin
          fill_only_we = 1'b1;
          lvl_wa       = t_r;
          lvl_wd       = fill_q - NW'(1);
        end
      end
      pic_pkg::OP_POP_LATCH: begin
        cont_we = 1'b1;
        cont_wa = j_r;
        cont_wd = '0;
      end
      pic_pkg::OP_PAR_RD: begin
        cont_ra = p_idx;
      end
      pic_pkg::OP_PAR_UPD: begin
        cont_we = 1'b1;
        cont_wa = p_idx;
        cont_wd = {1'b1, cont_q.c + (c_r >> 1)};
        fill_ra = dep_a_q;
      end
      pic_pkg::OP_PAR_PUSH: begin
        stack_we     = 1'b1;
        fill_only_we = 1'b1;
        lvl_wa       = p_lv_r;
        lvl_wd       = fill_q + NW'(1);
      end
      default: begin
        cont_we = 1'b0;
      end
    endcase
  end

  // Memory blocks.
  always_ff @(posedge clk) begin
    if (cmd.op == pic_pkg::OP_STORE) begin
      sire_mem[i_idx]  <= s_idx;
      dam_mem[i_idx]   <= d_idx;
      depth_mem[i_idx] <= lap_r;
      var_mem[i_idx]   <= var_r;
    end
    sire_q  <= sire_mem[stack_q];
    dam_q   <= dam_mem[stack_q];
    var_q   <= var_mem[stack_q];
    dep_a_q <= depth_mem[(cmd.op == pic_pkg::OP_PAR_RD) ? p_idx : s_idx];
    dep_b_q <= depth_mem[d_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == pic_pkg::OP_FIN) f_mem[i_idx] <= f_r;
    f_a_q <= f_mem[s_idx];
    f_b_q <= f_mem[d_idx];
  end

  always_ff @(posedge clk) begin
    if (cont_we) cont_mem[cont_wa] <= cont_wd;
    cont_q <= cont_mem[cont_ra];
  end

  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_wa] <= stack_wd;
    stack_q <= stack_mem[fill_q - NW'(1)];
  end

  always_ff @(posedge clk) begin
    if (lvl_we) base_mem[lvl_wa] <= lvl_wd;
    base_q <= base_mem[base_ra];
  end

  always_ff @(posedge clk) begin
    if (lvl_we || fill_only_we) fill_mem[lvl_wa] <= lvl_wd;
    fill_q <= fill_mem[fill_ra];
  end

  // Squared contribution times variance, cut into two partial products.
  logic [2*CW-1:0] sq_full;
  logic [62:0]     plo_full;
  logic [32:0]     phi_full;
  logic [65:0]     prod_sum;

  assign sq_full  = cont_q.c * cont_q.c;
  assign plo_full = sq_r[31:0] * v_r;
  assign phi_full = sq_r[SQW-1:32] * v_r;
  assign prod_sum = {1'b0, phi_r, 32'b0} + 66'(plo_r);

  always_ff @(posedge clk) begin
    plo_r  <= plo_full;
    phi_r  <= phi_full;
    prod_r <= prod_sum[65:pic_pkg::FRAC_BITS];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      hiwater_r    <= '0;
      prev_valid_r <= 1'b0;
      clr_r        <= '0;
    end else begin
      case (cmd.op)
        pic_pkg::OP_CLR: begin
          clr_r <= clr_r + NW'(1);
        end
        pic_pkg::OP_ACCEPT: begin
          if (in_data.restart) begin
            count_r      <= '0;
            hiwater_r    <= '0;
            prev_valid_r <= 1'b0;
          end
        end
        pic_pkg::OP_INC_WR: begin
          if (k_r == lap_r && lap_plus > hiwater_r) hiwater_r <= lap_plus;
        end
        pic_pkg::OP_FIN: begin
          count_r      <= i_idx;
          prev_valid_r <= 1'b1;
        end
        default: begin
          clr_r <= clr_r;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      pic_pkg::OP_ACCEPT: begin
        s_r <= in_data.sire;
        d_r <= in_data.dam;
      end
      pic_pkg::OP_PARENTS: begin
        lap_r <= lap_calc;
        var_r <= var_calc;
        k_r   <= '0;
      end
      pic_pkg::OP_INC_WR: begin
        if (k_r == lap_r) begin
          lapbase_r <= inc_val;
        end else begin
          k_r <= k_r + LW'(1);
        end
      end
      pic_pkg::OP_STORE: begin
        f_r   <= (s_known && d_known && repeat_hit) ? prev_f_r : '0;
        acc_r <= '0;
      end
      pic_pkg::OP_WINIT: begin
        t_r <= lap_r;
      end
      pic_pkg::OP_LVL_POP: begin
        if (fill_q > base_q) begin
          pos_r  <= fill_q - NW'(1);
          base_r <= base_q;
        end else if (t_r != '0) begin
          t_r <= t_r - LW'(1);
        end
      end
      pic_pkg::OP_POP_RD: begin
        j_r <= stack_q;
      end
      pic_pkg::OP_POP_LATCH: begin
        c_r   <= cont_q.c;
        ps_r  <= sire_q;
        pd_r  <= dam_q;
        v_r   <= var_q;
        sq_r  <= sq_full[2*CW-1:pic_pkg::FRAC_BITS];
        sel_r <= 1'b0;
      end
      pic_pkg::OP_PAR_RD: begin
        if (p_idx == '0) sel_r <= 1'b1;
      end
      pic_pkg::OP_PAR_UPD: begin
        p_lv_r <= dep_a_q;
        if (cont_q.flag) sel_r <= 1'b1;
      end
      pic_pkg::OP_PAR_PUSH: begin
        sel_r <= 1'b1;
      end
      pic_pkg::OP_ACC: begin
        acc_r <= acc_r + 64'(prod_r);
        if (pos_r == base_r && t_r != '0) t_r <= t_r - LW'(1);
      end
      pic_pkg::OP_RESULT: begin
        f_r <= f_calc;
      end
      pic_pkg::OP_FIN: begin
        prev_s_r <= s_idx;
        prev_d_r <= d_idx;
        prev_f_r <= f_r;
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == pic_pkg::OP_FIN) begin
      out_r.animal_number <= NUM_W_L'(i_idx);
      out_r.inbreeding    <= f_r;
      out_r.error         <= 1'b0;
    end else if (cmd.op == pic_pkg::OP_ERR) begin
      out_r.animal_number <= '0;
      out_r.inbreeding    <= '0;
      out_r.error         <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Status to the controller.
  always_comb begin
    stat.clr_done  = (clr_r == TBL_LAST);
    stat.err       = (count_r >= CNT_MAX) || (32'(s_r) > 32'(count_r))
                  || (32'(d_r) > 32'(count_r));
    stat.no_walk   = !s_known || !d_known || repeat_hit;
    stat.lap_done  = (k_r == lap_r);
    stat.lvl_empty = (fill_q <= base_q);
    stat.t_zero    = (t_r == '0);
    stat.par_zero  = (p_idx == '0);
    stat.par_seen  = cont_q.flag;
    stat.par_last  = sel_r;
    stat.lvl_done  = (pos_r == base_r);
    stat.out_free  = out_free;
  end

  // A refused record carries neither a number nor a coefficient.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.error) |-> (out_r.animal_number == '0 && out_r.inbreeding == '0))
    else $error("error result carries payload");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.inbreeding <= pic_pkg::F_ONE))
    else $error("coefficient above one");

  // A level is never popped below its base.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == pic_pkg::OP_ACC) |-> (pos_r >= base_r))
    else $error("ancestor stack popped below level base");

  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CNT_MAX) && (hiwater_r <= HW_MAX))
    else $error("animal count or level mark out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == pic_pkg::OP_FIN) |=> (count_r == $past(i_idx)))
    else $error("animal count not advanced on store");

endmodule

@@ rtl/pedigree_inbreeding_coefficients.sv @@
// ----------------------------------------------------------------------------
// Pedigree inbreeding coefficients
// Numbers each pedigree record and returns its inbreeding coefficient from a
// deepest-first walk of its ancestry through on-chip tables.
// ----------------------------------------------------------------------------
// Throughput: one record at a time, set by the ancestor walk over the memories.
// Reset: a clearing pass zeroes the contribution memory; input is stalled
// until it ends. Restart clears the store at once.
module pedigree_inbreeding_coefficients #(
  parameter int MAX_ANIMALS = pic_pkg::MAX_ANIMALS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pic_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pic_pkg::out_item_t  out_data
);

  pic_pkg::cmd_t  cmd;
  pic_pkg::stat_t stat;

  pic_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pic_dp #(
    .MAX_ANIMALS (MAX_ANIMALS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pedigree inbreeding coefficients: testbench
// Sends pedigree records through the valid/stall input channel and compares
// every result transaction with a software predictor of the ancestor walk.
// Covers founders, repeated parents, bad parents, restarts and deep inbred
// chains, then random pedigrees with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int              NANIM      = pic_pkg::MAX_ANIMALS_DEF;
  localparam int              TBL        = NANIM + 1;
  localparam int              CYCLE_CAP  = 4000000;
  localparam int              RANDOM_CNT = 1595;
  localparam int              NUM_W      = pic_pkg::NUM_W;
  localparam int              F_W        = pic_pkg::F_W;
  localparam int              FRAC_BITS  = pic_pkg::FRAC_BITS;
  localparam longint unsigned FIX_ONE    = pic_pkg::FIX_ONE;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  pic_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  pic_pkg::out_item_t out_data;

  pedigree_inbreeding_coefficients dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Predictor state: the pedigree store as the block should hold it.
  int unsigned     ped_sire [TBL];
  int unsigned     ped_dam  [TBL];
  longint unsigned ped_inbr [TBL];
  longint unsigned ped_var  [TBL];
  int              ped_depth[TBL];
  longint unsigned contrib  [TBL];
  bit              queued   [TBL];
  int unsigned     lvl_base [NANIM];
  int unsigned     lvl_fill [NANIM];
  int unsigned     anc_stack[TBL];
  int unsigned     herd_size;

  pic_pkg::out_item_t expected_q[$];
  int        fail_cnt;
  int        result_cnt;
  int        error_cnt;
  int        walk_cnt;
  int        cycles = 0;
  int        burst_left;

  function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return 64'(p >> FRAC_BITS);
  endfunction

  function automatic void stack_push(int unsigned a);
    int lv;
    lv = ped_depth[a];
    if (lv < 0 || lv >= NANIM) return;
    if (lvl_fill[lv] >= TBL) return;
    anc_stack[lvl_fill[lv]] = a;
    lvl_fill[lv]++;
    queued[a] = 1'b1;
  endfunction

  function automatic void hand_to_parent(int unsigned p, longint unsigned half);
    if (p == 0 || p >= TBL) return;
    if (!queued[p]) stack_push(p);
    contrib[p] += half;
  endfunction

  // Deepest-first ancestor walk; returns the sum of c^2 * variance.
  function automatic longint unsigned ancestry_sum(int unsigned me, int top);
    longint unsigned acc;
    longint unsigned c;
    int t;
    int unsigned j;
    int unsigned pos;
    acc = 0;
    t = top;
    contrib[me] = FIX_ONE;
    stack_push(me);
    while (t >= 0) begin
      if (lvl_fill[t] <= lvl_base[t]) begin
        t--;
        continue;
      end
      lvl_fill[t]--;
      pos = lvl_fill[t];
      if (pos >= TBL) begin
        t--;
        continue;
      end
      j = anc_stack[pos];
      if (j >= TBL) j = 0;
      c = contrib[j];
      hand_to_parent(ped_sire[j], c >> 1);
      hand_to_parent(ped_dam[j], c >> 1);
      acc += fx_mul(fx_mul(c, c), ped_var[j]);
      contrib[j] = 0;
      queued[j] = 1'b0;
      if (lvl_fill[t] == lvl_base[t]) t--;
    end
    return acc;
  endfunction

  function automatic pic_pkg::out_item_t predict_record(pic_pkg::in_item_t rec);
    pic_pkg::out_item_t r;
    int unsigned     s, d, me;
    int              ds, dd, top;
    longint unsigned v, known, f, acc;
    s = rec.sire;
    d = rec.dam;
    r = '0;
    if (rec.restart) begin
      herd_size = 0;
      foreach (lvl_base[k]) begin
        lvl_base[k] = 0;
        lvl_fill[k] = 0;
      end
    end
    if (herd_size >= NANIM || s > herd_size || d > herd_size) begin
      r.error = 1'b1;
      return r;
    end
    me = herd_size + 1;
    ds = s ? ped_depth[s] : -1;
    dd = d ? ped_depth[d] : -1;
    top = ((ds > dd) ? ds : dd) + 1;
    if (top >= NANIM) top = NANIM - 1;
    v = FIX_ONE >> 1;
    known = 0;
    if (s != 0) known += ped_inbr[s]; else v += FIX_ONE >> 2;
    if (d != 0) known += ped_inbr[d]; else v += FIX_ONE >> 2;
    known >>= 2;
    v = (v > known) ? v - known : 0;
    for (int k = 0; k < top; k++) begin
      lvl_base[k]++;
      lvl_fill[k]++;
    end
    ped_sire[me] = s;
    ped_dam[me] = d;
    ped_depth[me] = top;
    ped_var[me] = v;
    if (s == 0 || d == 0) begin
      f = 0;
    end else if (herd_size >= 1 && ped_sire[herd_size] == s && ped_dam[herd_size] == d) begin
      f = ped_inbr[herd_size];
    end else begin
      acc = ancestry_sum(me, top);
      walk_cnt++;
      f = (acc > FIX_ONE) ? acc - FIX_ONE : 0;
      if (f > FIX_ONE) f = FIX_ONE;
    end
    ped_inbr[me] = f;
    herd_size = me;
    r.animal_number = NUM_W'(me);
    r.inbreeding = F_W'(f);
    return r;
  endfunction

  // Sends one record in bursts with random gaps, then predicts its result.
  task automatic send_record(bit rs, int unsigned s, int unsigned d);
    pic_pkg::in_item_t rec;
    int gap;
    rec.restart = rs;
    rec.sire = NUM_W'(s);
    rec.dam = NUM_W'(d);
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= rec;
    do @(posedge clk); while (!(in_valid && !in_stall));
    expected_q.push_back(predict_record(rec));
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Receiver stalls follow their own changing pattern.
  int stall_pct = 0;
  always @(negedge clk) begin
    if (cycles % 256 == 0) stall_pct <= $urandom_range(0, 3) * 25;
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    pic_pkg::out_item_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
      $display("TEST FAILED");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, out_data);
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        result_cnt++;
        if (want.error) error_cnt++;
        if (out_data.animal_number !== want.animal_number ||
            out_data.inbreeding !== want.inbreeding || out_data.error !== want.error) begin
          $display("%0t: mismatch, expected num=%0d f=%h err=%0d, actual num=%0d f=%h err=%0d",
                   $time, want.animal_number, want.inbreeding, want.error,
                   out_data.animal_number, out_data.inbreeding, out_data.error);
          fail_cnt++;
        end
      end
    end
  end

  task automatic test_special_cases();
    send_record(1'b0, 0, 0);
    send_record(1'b0, 0, 0);
    send_record(1'b0, 1, 2);
    send_record(1'b0, 1, 2);      // same parents as previous animal
    send_record(1'b0, 3, 4);      // full-sib mating
    send_record(1'b0, 5, 0);      // unknown dam
    send_record(1'b0, 0, 5);      // unknown sire
    send_record(1'b0, 5, 3);
    send_record(1'b0, 9, 1);      // sire not yet stored
    send_record(1'b0, 1, 8191);   // dam far out of range
    send_record(1'b1, 1, 7);      // restart still clears the store on error
    send_record(1'b0, 0, 0);
    send_record(1'b1, 0, 0);
    send_record(1'b0, 1, 1);      // selfing
    send_record(1'b0, 2, 1);
  endtask

  // A long inbred chain pushes founder contributions below one LSB.
  task automatic test_deep_chain();
    send_record(1'b1, 0, 0);
    send_record(1'b0, 0, 0);
    for (int k = 3; k <= 40; k++) send_record(1'b0, k - 1, k - 2);
  endtask

  task automatic test_random_pedigrees();
    int unsigned n, s, d, lo;
    int sel;
    for (int k = 0; k < RANDOM_CNT; k++) begin
      n = herd_size;
      sel = $urandom_range(0, 99);
      lo = (n > 8) ? n - 8 : 1;
      if (n >= 36 || sel < 3) begin
        send_record(1'b1, $urandom_range(0, 1) ? 0 : $urandom_range(0, 8191),
                    $urandom_range(0, 1) ? 0 : $urandom_range(0, 8191));
      end else if (n < 2 || sel < 18) begin
        s = $urandom_range(0, 1) ? 0 : $urandom_range(0, n);
        d = $urandom_range(0, 1) ? 0 : $urandom_range(0, n);
        send_record(1'b0, s, d);
      end else if (sel < 28) begin
        send_record(1'b0, ped_sire[n], ped_dam[n]);
      end else if (sel < 33) begin
        send_record(1'b0, $urandom_range(n + 1, 8191), $urandom_range(0, 8191));
      end else begin
        send_record(1'b0, $urandom_range(lo, n), $urandom_range(lo, n));
      end
    end
  endtask

  initial begin
    fail_cnt = 0;
    result_cnt = 0;
    error_cnt = 0;
    walk_cnt = 0;
    burst_left = 0;
    herd_size = 0;
    foreach (contrib[k]) begin
      contrib[k] = 0;
      queued[k] = 1'b0;
    end
    foreach (lvl_base[k]) begin
      lvl_base[k] = 0;
      lvl_fill[k] = 0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_special_cases();
    test_deep_chain();
    test_random_pedigrees();
    drop_valid();
    wait (expected_q.size() == 0);
    repeat (200) @(posedge clk);
    $display("Checked %0d results (%0d refused records, %0d ancestor walks)",
             result_cnt, error_cnt, walk_cnt);
    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
